@@ src/running_min_max_average_macros.svh @@
// Assertion macros for the running min/max/average block.
`ifndef RUNNING_MIN_MAX_AVERAGE_MACROS_SVH
`define RUNNING_MIN_MAX_AVERAGE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RMMA_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rmma check failed");

// Implication checked from one clock edge to the next.
`define RMMA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rmma check failed");

`endif

@@ src/rmma_pkg.sv @@
// Shared types and constants for the running min/max/average block.
`timescale 1ns / 1ps

package rmma_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int COUNT_BITS  = 16;
	localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS;
	localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [TOTAL_BITS-1:0]  total_t;
	typedef logic [STEP_BITS-1:0]   step_t;
	typedef logic [1:0]             opcode_t;

	localparam sample_t SAMPLE_MAX  = '1;
	localparam count_t  COUNT_LIMIT = '1;

	// Command codes
	localparam opcode_t OP_SAMPLE = 2'd0;
	localparam opcode_t OP_START  = 2'd1;
	localparam opcode_t OP_RESET  = 2'd2;

endpackage

@@ src/rmma_div.sv @@
// Restoring divider: one quotient bit per cycle, quotient known to fit a sample code.
`timescale 1ns / 1ps

module rmma_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rmma_pkg::total_t dividend,
	input  rmma_pkg::count_t divisor,
	output logic            busy,
	output rmma_pkg::sample_t quotient
);
	import rmma_pkg::*;

	localparam step_t LAST_STEP = step_t'(SAMPLE_BITS - 1);

	logic    busy_q;
	step_t   step_q;
	count_t  rem_q;
	sample_t low_q;
	sample_t quo_q;
	count_t  divisor_q;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic                fits;
	count_t              rem_nxt;

	// One compare-subtract step
	always_comb begin
		trial   = {rem_q, low_q[SAMPLE_BITS-1]};
		diff    = trial - {1'b0, divisor_q};
		fits    = (trial >= {1'b0, divisor_q});
		rem_nxt = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= LAST_STEP;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - step_t'(1);
		end
	end

	// Datapath; the upper dividend bits are already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= dividend[TOTAL_BITS-1:SAMPLE_BITS];
			low_q     <= dividend[SAMPLE_BITS-1:0];
			quo_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[SAMPLE_BITS-2:0], 1'b0};
			quo_q <= {quo_q[SAMPLE_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	// zero divisor guarded to a zero mean
	assign quotient = (divisor_q != '0) ? quo_q : '0;

endmodule

@@ src/running_min_max_average.sv @@
// Top level of the running min/max/average statistics block.
// Takes commands and 10-bit converter samples on a valid/ready input channel.
// A start command arms the block, a reset command clears the statistics and
// stops it; neither gives a result. While running, a sample updates minimum,
// maximum, a saturating count and the sum, then the mean floor(sum / count) is
// formed by an iterative divider retiring one quotient bit per cycle, so a
// sample occupies the block through its accept, 10 divide steps and the load
// of the output register, which waits for room there. The result sits in an
// output register, so the next beat is taken while it waits. Samples while
// stopped and unused opcodes are accepted and dropped. Once the count reaches
// its limit, sum and count freeze and saturated is raised.
`timescale 1ns / 1ps

module running_min_max_average (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rmma_pkg::opcode_t  opcode,
	input  rmma_pkg::sample_t  sample,
	output logic               out_valid,
	input  logic               out_ready,
	output rmma_pkg::sample_t  current,
	output rmma_pkg::sample_t  lowest,
	output rmma_pkg::sample_t  highest,
	output rmma_pkg::sample_t  mean,
	output rmma_pkg::count_t   samples_seen,
	output logic               saturated
);
	import rmma_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t  state_q;
	logic    running_q;
	total_t  total_q;
	count_t  tally_q;
	sample_t min_q;
	sample_t max_q;
	sample_t cur_q;

	logic    out_valid_q;
	sample_t current_q;
	sample_t lowest_q;
	sample_t highest_q;
	sample_t mean_q;
	count_t  seen_q;
	logic    sat_q;

	logic    accept;
	logic    take_sample;
	logic    room;
	logic    load;
	total_t  total_nxt;
	count_t  tally_nxt;
	logic    div_busy;
	sample_t div_quo;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign take_sample = accept && (opcode == OP_SAMPLE) && running_q;
	assign room     = !out_valid_q || out_ready;
	assign load     = (state_q == S_DIV) && !div_busy && room;

	// Next sum and count, frozen at the limit
	always_comb begin
		if (tally_q != COUNT_LIMIT) begin
			total_nxt = total_q + total_t'(sample);
			tally_nxt = tally_q + count_t'(1);
		end else begin
			total_nxt = total_q;
			tally_nxt = tally_q;
		end
	end

	rmma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take_sample),
		.dividend (total_nxt),
		.divisor  (tally_nxt),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Sequencer, statistics and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			total_q     <= '0;
			tally_q     <= '0;
			min_q       <= SAMPLE_MAX;
			max_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			current_q   <= '0;
			lowest_q    <= '0;
			highest_q   <= '0;
			mean_q      <= '0;
			seen_q      <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_START) begin
							running_q <= 1'b1;
						end else if (opcode == OP_RESET) begin
							running_q <= 1'b0;
							total_q   <= '0;
							tally_q   <= '0;
							min_q     <= SAMPLE_MAX;
							max_q     <= '0;
						end else if (take_sample) begin
							cur_q   <= sample;
							total_q <= total_nxt;
							tally_q <= tally_nxt;
							if (sample < min_q) begin
								min_q <= sample;
							end
							if (sample > max_q) begin
								max_q <= sample;
							end
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (load) begin
						current_q   <= cur_q;
						lowest_q    <= min_q;
						highest_q   <= max_q;
						mean_q      <= div_quo;
						seen_q      <= tally_q;
						sat_q       <= (tally_q == COUNT_LIMIT);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign current      = current_q;
	assign lowest       = lowest_q;
	assign highest      = highest_q;
	assign mean         = mean_q;
	assign samples_seen = seen_q;
	assign saturated    = sat_q;

endmodule

@@ src/rmma_chk.sv @@
// Port-level checks for the running min/max/average block, bound to the top level.
`timescale 1ns / 1ps
`include "running_min_max_average_macros.svh"

module rmma_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input rmma_pkg::sample_t  current,
	input rmma_pkg::sample_t  lowest,
	input rmma_pkg::sample_t  highest,
	input rmma_pkg::sample_t  mean,
	input rmma_pkg::count_t   samples_seen,
	input logic               saturated
);
	import rmma_pkg::*;

	logic order_ok;

	assign order_ok = (lowest <= current) && (current <= highest) &&
		(lowest <= mean) && (mean <= highest);

	// A stalled result beat holds
	`RMMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mean) && $stable(current))
	// Statistics are ordered: min <= current, mean <= max
	`RMMA_ASSERT(a_order, !out_valid || order_ok)
	// A result always follows at least one sample
	`RMMA_ASSERT(a_count_nonzero, !out_valid || samples_seen != '0)
	// Saturation flag only at the count limit
	`RMMA_ASSERT(a_sat_limit, !out_valid || (saturated == (samples_seen == COUNT_LIMIT)))

endmodule

bind running_min_max_average rmma_chk u_chk (.*);

@@ dv/tb_running_min_max_average.sv @@
// Testbench for the running min/max/average block: directed and random checks.
`timescale 1ns / 1ps

module tb_running_min_max_average;
	import rmma_pkg::*;

	localparam opcode_t OP_UNUSED   = 2'd3;
	localparam int      CYCLE_LIMIT = 4_000_000;
	localparam int      PRINT_CAP   = 60;

	// One result beat as the block presents it
	typedef struct packed {
		sample_t current;
		sample_t lowest;
		sample_t highest;
		sample_t mean;
		count_t  seen;
		logic    sat;
	} stats_t;

	// Tracks the statistics, queues the expected results and compares them
	class stats_scoreboard;
		bit      running;
		total_t  sum;
		count_t  tally;
		sample_t lo;
		sample_t hi;
		stats_t  pending[$];
		int      n_errs;
		int      n_results;

		function new();
			n_errs    = 0;
			n_results = 0;
			clear();
		endfunction

		function void clear();
			running = 1'b0;
			sum     = '0;
			tally   = '0;
			lo      = SAMPLE_MAX;
			hi      = '0;
		endfunction

		// Accepted input beat: update the statistics, queue a result for a live sample
		function void note_beat(opcode_t op, sample_t s_in);
			stats_t want;
			total_t quot;
			case (op)
				OP_START: running = 1'b1;
				OP_RESET: clear();
				OP_SAMPLE: begin
					if (running) begin
						if (s_in < lo) lo = s_in;
						if (s_in > hi) hi = s_in;
						// sum and count freeze once the count hits its ceiling
						if (tally != COUNT_LIMIT) begin
							sum   = sum + total_t'(s_in);
							tally = tally + 1'b1;
						end
						quot         = (tally != '0) ? sum / total_t'(tally) : '0;
						want.current = s_in;
						want.lowest  = lo;
						want.highest = hi;
						want.mean    = quot[SAMPLE_BITS-1:0];
						want.seen    = tally;
						want.sat     = (tally == COUNT_LIMIT);
						pending.push_back(want);
						n_results++;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			if (n_errs < PRINT_CAP)
				$display("ERROR @%0t: %s", $realtime, msg);
			n_errs++;
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got !== want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		// Accepted result beat: compare against the oldest expectation
		task check_result(stats_t got);
			stats_t want;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (^got === 1'bx)
				report("result beat carries X/Z");
			check_field("current", got.current, want.current);
			check_field("lowest", got.lowest, want.lowest);
			check_field("highest", got.highest, want.highest);
			check_field("mean", got.mean, want.mean);
			check_field("samples_seen", got.seen, want.seen);
			check_field("saturated", got.sat, want.sat);
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	opcode_t opcode;
	sample_t sample;
	logic    out_valid;
	logic    out_ready;
	sample_t current;
	sample_t lowest;
	sample_t highest;
	sample_t mean;
	count_t  samples_seen;
	logic    saturated;

	stats_scoreboard sb;
	int unsigned     cycles;
	int              tx_gap_pct;
	bit              rx_quiet;

	running_min_max_average u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current      (current),
		.lowest       (lowest),
		.highest      (highest),
		.mean         (mean),
		.samples_seen (samples_seen),
		.saturated    (saturated)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("running_min_max_average: mismatch");
			$finish;
		end
	end

	// Handshake monitor: values read here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beat(opcode, sample);
			if (out_valid && out_ready)
				sb.check_result('{current, lowest, highest, mean, samples_seen, saturated});
		end
	end

	// Result side back-pressure: random stall bursts, none once quiet
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!rx_quiet && $urandom_range(0, 1)) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	// Converter code with weight on the ends of the range
	function automatic sample_t pick_code();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return SAMPLE_MAX;
			2:       return sample_t'($urandom_range(0, 15));
			3:       return sample_t'($urandom_range(1008, 1023));
			default: return sample_t'($urandom_range(0, 1023));
		endcase
	endfunction

	// Present one beat and hold it until taken; called at a rising edge
	task automatic send_beat(opcode_t op, sample_t s_in);
		if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		sample   <= s_in;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Random sessions: mostly start + sample runs, with resets and noise mixed in
	task automatic run_sessions(int goal);
		int r;
		while (sb.n_results < goal) begin
			tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
			if ($urandom_range(0, 2) == 0)
				send_beat(OP_RESET, pick_code());
			if ($urandom_range(0, 5) == 0)
				send_beat(OP_SAMPLE, pick_code());
			send_beat(OP_START, pick_code());
			repeat ($urandom_range(1, 40)) begin
				r = $urandom_range(0, 99);
				if (r < 88)
					send_beat(OP_SAMPLE, pick_code());
				else if (r < 92)
					send_beat(OP_START, pick_code());
				else if (r < 96)
					send_beat(OP_UNUSED, pick_code());
				else
					send_beat(OP_RESET, pick_code());
			end
		end
	endtask

	initial begin
		sb         = new();
		tx_gap_pct = 30;
		rx_quiet   = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_SAMPLE;
		sample    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stopped samples, unused code, double start, extremes, reset
		send_beat(OP_SAMPLE, 10'd512);
		send_beat(OP_UNUSED, SAMPLE_MAX);
		send_beat(OP_START, '0);
		send_beat(OP_START, SAMPLE_MAX);
		send_beat(OP_SAMPLE, '0);
		send_beat(OP_SAMPLE, SAMPLE_MAX);
		send_beat(OP_SAMPLE, 10'd1);
		send_beat(OP_SAMPLE, 10'd1022);
		send_beat(OP_SAMPLE, 10'h155);
		send_beat(OP_SAMPLE, 10'h2AA);
		send_beat(OP_UNUSED, '0);
		send_beat(OP_RESET, SAMPLE_MAX);
		send_beat(OP_SAMPLE, 10'd7);
		send_beat(OP_START, 10'h155);
		send_beat(OP_SAMPLE, SAMPLE_MAX);
		send_beat(OP_SAMPLE, SAMPLE_MAX);
		send_beat(OP_SAMPLE, '0);
		send_beat(OP_SAMPLE, 10'd5);
		send_beat(OP_RESET, '0);
		send_beat(OP_START, 10'h2AA);
		send_beat(OP_SAMPLE, 10'd300);

		// Random, with one full drain halfway through
		run_sessions(150);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		run_sessions(290);

		// Closing run, no idling on either side from here on
		tx_gap_pct = 0;
		rx_quiet   = 1'b1;
		send_beat(OP_RESET, pick_code());
		send_beat(OP_START, pick_code());
		repeat (30)
			send_beat(OP_SAMPLE, sample_t'($urandom_range(0, 1023)));
		send_beat(OP_START, pick_code());
		send_beat(OP_UNUSED, pick_code());
		send_beat(OP_SAMPLE, '0);
		send_beat(OP_SAMPLE, SAMPLE_MAX);
		send_beat(OP_SAMPLE, pick_code());

		// Drain and settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report("expected results never arrived");
		if (sb.n_errs == 0) begin
			$display("running_min_max_average: match");
		end else begin
			$display("running_min_max_average: mismatch");
		end
		$finish;
	end

endmodule
